FILE: sv/svr_pkg.sv
// Shared widths, register codes and divider interface types for the servo ramp block.
package svr_pkg;

   localparam int POS_W      = 7;
   localparam int ANGLE_W    = 8;
   localparam int TIME_W     = 15;
   localparam int ELAPSED_W  = 16;
   localparam int DIVIDEND_W = 15;
   localparam int DIVISOR_W  = 7;
   localparam int CSR_IDX_W  = 2;

   localparam int DEFAULT_POSITION_SCALE = 100;

   localparam logic [POS_W-1:0] NO_TARGET = 7'd127;

   localparam logic [CSR_IDX_W-1:0] CSR_ROTATE_LEFT_END  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ROTATE_RIGHT_END = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TILT_DOWN_END    = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_TILT_UP_END      = 2'd3;

   localparam logic [ANGLE_W-1:0] RESET_ROTATE_LEFT_END  = 8'd0;
   localparam logic [ANGLE_W-1:0] RESET_ROTATE_RIGHT_END = 8'd180;
   localparam logic [ANGLE_W-1:0] RESET_TILT_DOWN_END    = 8'd180;
   localparam logic [ANGLE_W-1:0] RESET_TILT_UP_END      = 8'd0;

   typedef struct packed {
      logic                  start;
      logic [DIVIDEND_W-1:0] dividend;
      logic [DIVISOR_W-1:0]  divisor;
   } div_req_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_sts_type;

endpackage

FILE: sv/svr_div.sv
// Restoring divider that produces one quotient bit per clock cycle.
module svr_div
   import svr_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  div_req_type           req,
   output div_sts_type           sts,
   output logic [DIVIDEND_W-1:0] quotient
);

   localparam int CNT_W = $clog2(DIVIDEND_W);
   localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(DIVIDEND_W - 1);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [DIVISOR_W-1:0]  rem_ff, rem_in;
   logic [DIVIDEND_W-1:0] quo_ff, quo_in;
   logic [DIVISOR_W-1:0]  dvs_ff, dvs_in;
   logic [DIVISOR_W:0]    rem_shift;

   assign rem_shift = {rem_ff, quo_ff[DIVIDEND_W-1]};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      if (req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = req.dividend;
         dvs_in  = req.divisor;
      end else if (busy_ff) begin
         // Shift in the next dividend bit and subtract when the divisor fits.
         if (rem_shift >= {1'b0, dvs_ff}) begin
            rem_in = DIVISOR_W'(rem_shift - {1'b0, dvs_ff});
            quo_in = {quo_ff[DIVIDEND_W-2:0], 1'b1};
         end else begin
            rem_in = rem_shift[DIVISOR_W-1:0];
            quo_in = {quo_ff[DIVIDEND_W-2:0], 1'b0};
         end
         cnt_in = CNT_W'(cnt_ff + 1'b1);
         if (cnt_ff == LAST_STEP) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign sts.busy = busy_ff;
   assign sts.done = done_ff;
   assign quotient = quo_ff;

endmodule

FILE: sv/two_axis_servo_ramp.sv
// Top level of the pan and tilt servo ramp generator with its sequencer and state.
//
// Each request word carries a mode (tuser: 0 ramp step, 1 immediate move), a
// millisecond tick, rotate and tilt targets on a 0 to POSITION_SCALE scale and a
// move duration in milliseconds; each one yields exactly one response word with
// the commanded angles, their write strobes and the in-position flag. Targets
// above the scale are saturated. When the targets change, each axis gets a step
// period of duration divided by distance, and an axis steps one unit once its
// elapsed milliseconds reach that period. Angles are end0 + pos*(end1-end0)/scale,
// truncated toward zero and clamped to the two configured ends. The period of an
// axis that has a distance to go comes from one shared 15-bit restoring divider,
// and the division by the scale in each commanded angle is a multiplication by
// its reciprocal. A ramp step that moves neither axis is the shortest case, an
// immediate move skips the period setup, and a target change that moves both
// axes is the longest. The block takes no request while it works on one; a
// finished response sits in an output register so the next request can be
// accepted before it is taken, and a response that is still held back stalls the
// block before it can hand over the next one. End angles may be written through
// the csr port only while the block is idle.
module two_axis_servo_ramp
   import svr_pkg::*;
#(
   parameter int POSITION_SCALE = DEFAULT_POSITION_SCALE
)
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   // [0] ms_elapsed, [7:1] rotate_target, [14:8] tilt_target,
   // [29:15] move_time_ms, [31:30] zero
   input  logic [31:0]          req_tdata,
   // [0] func
   input  logic                 req_tuser,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   // [7:0] rotate_angle, [8] rotate_write, [16:9] tilt_angle, [17] tilt_write,
   // [18] in_position, [23:19] zero
   output logic [23:0]          rsp_tdata,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [ANGLE_W-1:0]   csr_data
);

   localparam logic [POS_W-1:0] SCALE = POS_W'(POSITION_SCALE);

   // Exact reciprocal of the scale for every product below 2**DIVIDEND_W.
   localparam int RECIP_SHIFT = DIVIDEND_W + $clog2(POSITION_SCALE);
   localparam logic [DIVIDEND_W:0] RECIP = (DIVIDEND_W+1)'(
      ((longint'(1) << RECIP_SHIFT) + longint'(POSITION_SCALE) - 1) /
      longint'(POSITION_SCALE));

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_SETUP = 3'd1;
   localparam logic [2:0] S_SWAIT = 3'd2;
   localparam logic [2:0] S_STEP  = 3'd3;
   localparam logic [2:0] S_MAP   = 3'd4;
   localparam logic [2:0] S_MDIV  = 3'd5;
   localparam logic [2:0] S_MWAIT = 3'd6;
   localparam logic [2:0] S_OUT   = 3'd7;

   logic [2:0]            state_ff, state_in;
   logic                  axis_ff, axis_in;
   logic [POS_W-1:0]      rt_ff, rt_in, tt_ff, tt_in;
   logic [TIME_W-1:0]     time_ff, time_in;
   logic [POS_W-1:0]      rpos_ff, rpos_in, tpos_ff, tpos_in;
   logic [POS_W-1:0]      rrem_ff, rrem_in, trem_ff, trem_in;
   logic                  rup_ff, rup_in, tup_ff, tup_in;
   logic [TIME_W-1:0]     rper_ff, rper_in, tper_ff, tper_in;
   logic [ELAPSED_W-1:0]  rel_ff, rel_in, tel_ff, tel_in;
   logic                  done_ff, done_in;
   logic                  rw_ff, rw_in, tw_ff, tw_in;
   logic [ANGLE_W-1:0]    rang_ff, rang_in, tang_ff, tang_in;
   logic [DIVIDEND_W-1:0] prod_ff, prod_in;
   logic                  neg_ff, neg_in;
   logic [ANGLE_W-1:0]    rle_ff, rre_ff, tde_ff, tue_ff;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [23:0]           rsp_data_ff, rsp_data_in;

   logic                  accept;
   logic [POS_W-1:0]      in_rt, in_tt;
   logic                  in_tick;
   logic [POS_W-1:0]      cur_pos, cur_tgt, gap;
   logic [ANGLE_W-1:0]    cur_end0, cur_end1, span_mag, lo, hi, angle;
   logic                  cur_wr, rstep, tstep;
   logic signed [ANGLE_W+1:0] sum;
   logic [2*DIVIDEND_W:0] recip_prod;
   logic [DIVIDEND_W-1:0] map_quo;
   div_req_type           div_req;
   div_sts_type           div_sts;
   logic [DIVIDEND_W-1:0] div_quo;

   svr_div u_div (
      .clock    (clock),
      .reset    (reset),
      .req      (div_req),
      .sts      (div_sts),
      .quotient (div_quo)
   );

   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign in_tick = req_tdata[0];
   assign in_rt   = (req_tdata[7:1] > SCALE) ? SCALE : req_tdata[7:1];
   assign in_tt   = (req_tdata[14:8] > SCALE) ? SCALE : req_tdata[14:8];

   // The sequencer walks the rotate axis first and the tilt axis second.
   assign cur_pos  = axis_ff ? tpos_ff : rpos_ff;
   assign cur_tgt  = axis_ff ? tt_ff : rt_ff;
   assign cur_end0 = axis_ff ? tde_ff : rle_ff;
   assign cur_end1 = axis_ff ? tue_ff : rre_ff;
   assign cur_wr   = axis_ff ? tw_ff : rw_ff;
   assign gap      = (cur_pos > cur_tgt) ? POS_W'(cur_pos - cur_tgt)
                                         : POS_W'(cur_tgt - cur_pos);
   assign span_mag = (cur_end1 < cur_end0) ? ANGLE_W'(cur_end0 - cur_end1)
                                           : ANGLE_W'(cur_end1 - cur_end0);
   assign lo       = (cur_end0 < cur_end1) ? cur_end0 : cur_end1;
   assign hi       = (cur_end0 < cur_end1) ? cur_end1 : cur_end0;

   // The product divided by the scale, truncated.
   assign recip_prod = (2*DIVIDEND_W+1)'(prod_ff) * (2*DIVIDEND_W+1)'(RECIP);
   assign map_quo    = DIVIDEND_W'(recip_prod >> RECIP_SHIFT);

   // The quotient magnitude never exceeds the span, so eight bits carry it.
   assign sum = neg_ff ? ($signed({2'b00, cur_end0}) - $signed({2'b00, prod_ff[ANGLE_W-1:0]}))
                       : ($signed({2'b00, cur_end0}) + $signed({2'b00, prod_ff[ANGLE_W-1:0]}));
   always_comb begin
      if (sum < $signed({2'b00, lo})) begin
         angle = lo;
      end else if (sum > $signed({2'b00, hi})) begin
         angle = hi;
      end else begin
         angle = sum[ANGLE_W-1:0];
      end
   end

   assign rstep = (rpos_ff != rt_ff) && (rel_ff >= {1'b0, rper_ff});
   assign tstep = (tpos_ff != tt_ff) && (tel_ff >= {1'b0, tper_ff});

   always_comb begin
      div_req.start    = 1'b0;
      div_req.dividend = time_ff;
      div_req.divisor  = gap;
      if (state_ff == S_SETUP) begin
         div_req.start = (gap != '0);
      end
   end

   always_comb begin
      state_in     = state_ff;
      axis_in      = axis_ff;
      rt_in        = rt_ff;
      tt_in        = tt_ff;
      time_in      = time_ff;
      rpos_in      = rpos_ff;
      tpos_in      = tpos_ff;
      rrem_in      = rrem_ff;
      trem_in      = trem_ff;
      rup_in       = rup_ff;
      tup_in       = tup_ff;
      rper_in      = rper_ff;
      tper_in      = tper_ff;
      rel_in       = rel_ff;
      tel_in       = tel_ff;
      done_in      = done_ff;
      rw_in        = rw_ff;
      tw_in        = tw_ff;
      rang_in      = rang_ff;
      tang_in      = tang_ff;
      prod_in      = prod_ff;
      neg_in       = neg_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               rt_in   = in_rt;
               tt_in   = in_tt;
               time_in = req_tdata[29:15];
               axis_in = 1'b0;
               if (in_tick) begin
                  if (rel_ff != '1) rel_in = ELAPSED_W'(rel_ff + 1'b1);
                  if (tel_ff != '1) tel_in = ELAPSED_W'(tel_ff + 1'b1);
               end
               if (req_tuser) begin
                  // Immediate move: jump, write both servos, force a new setup later.
                  rpos_in  = in_rt;
                  tpos_in  = in_tt;
                  rw_in    = 1'b1;
                  tw_in    = 1'b1;
                  done_in  = 1'b1;
                  rrem_in  = NO_TARGET;
                  trem_in  = NO_TARGET;
                  state_in = S_MAP;
               end else if ((rrem_ff != in_rt) || (trem_ff != in_tt)) begin
                  rrem_in  = in_rt;
                  trem_in  = in_tt;
                  done_in  = 1'b0;
                  rup_in   = (rpos_ff < in_rt);
                  tup_in   = (tpos_ff < in_tt);
                  rel_in   = '0;
                  tel_in   = '0;
                  state_in = S_SETUP;
               end else begin
                  state_in = S_STEP;
               end
            end
         end
         S_SETUP: begin
            if (gap == '0) begin
               if (axis_ff) tper_in = '0;
               else         rper_in = '0;
               axis_in  = !axis_ff;
               state_in = axis_ff ? S_STEP : S_SETUP;
            end else begin
               state_in = S_SWAIT;
            end
         end
         S_SWAIT: begin
            if (div_sts.done) begin
               if (axis_ff) tper_in = div_quo;
               else         rper_in = div_quo;
               axis_in  = !axis_ff;
               state_in = axis_ff ? S_STEP : S_SETUP;
            end
         end
         S_STEP: begin
            // The done check sees the positions before this item's steps.
            if ((rpos_ff == rt_ff) && (tpos_ff == tt_ff)) done_in = 1'b1;
            rw_in = rstep;
            tw_in = tstep;
            if (rstep) begin
               rpos_in = rup_ff ? POS_W'(rpos_ff + 1'b1) : POS_W'(rpos_ff - 1'b1);
               rel_in  = '0;
            end
            if (tstep) begin
               tpos_in = tup_ff ? POS_W'(tpos_ff + 1'b1) : POS_W'(tpos_ff - 1'b1);
               tel_in  = '0;
            end
            axis_in  = 1'b0;
            state_in = S_MAP;
         end
         S_MAP: begin
            if (cur_wr) begin
               prod_in  = DIVIDEND_W'(cur_pos) * DIVIDEND_W'(span_mag);
               neg_in   = (cur_end1 < cur_end0);
               state_in = S_MDIV;
            end else begin
               if (axis_ff) tang_in = '0;
               else         rang_in = '0;
               axis_in  = !axis_ff;
               state_in = axis_ff ? S_OUT : S_MAP;
            end
         end
         S_MDIV: begin
            // Scale the product down; the quotient takes the place of the product.
            prod_in  = map_quo;
            state_in = S_MWAIT;
         end
         S_MWAIT: begin
            if (axis_ff) tang_in = angle;
            else         rang_in = angle;
            axis_in  = !axis_ff;
            state_in = axis_ff ? S_OUT : S_MAP;
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_data_in  = {5'd0, done_ff, tw_ff, tang_ff, rw_ff, rang_ff};
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         axis_ff      <= 1'b0;
         rpos_ff      <= '0;
         tpos_ff      <= '0;
         rrem_ff      <= NO_TARGET;
         trem_ff      <= NO_TARGET;
         rup_ff       <= 1'b0;
         tup_ff       <= 1'b0;
         rper_ff      <= '0;
         tper_ff      <= '0;
         rel_ff       <= '0;
         tel_ff       <= '0;
         done_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         axis_ff      <= axis_in;
         rpos_ff      <= rpos_in;
         tpos_ff      <= tpos_in;
         rrem_ff      <= rrem_in;
         trem_ff      <= trem_in;
         rup_ff       <= rup_in;
         tup_ff       <= tup_in;
         rper_ff      <= rper_in;
         tper_ff      <= tper_in;
         rel_ff       <= rel_in;
         tel_ff       <= tel_in;
         done_ff      <= done_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rt_ff       <= rt_in;
      tt_ff       <= tt_in;
      time_ff     <= time_in;
      rw_ff       <= rw_in;
      tw_ff       <= tw_in;
      rang_ff     <= rang_in;
      tang_ff     <= tang_in;
      prod_ff     <= prod_in;
      neg_ff      <= neg_in;
      rsp_data_ff <= rsp_data_in;
   end

   // End angle registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         rle_ff <= RESET_ROTATE_LEFT_END;
         rre_ff <= RESET_ROTATE_RIGHT_END;
         tde_ff <= RESET_TILT_DOWN_END;
         tue_ff <= RESET_TILT_UP_END;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_ROTATE_LEFT_END:  rle_ff <= csr_data;
            CSR_ROTATE_RIGHT_END: rre_ff <= csr_data;
            CSR_TILT_DOWN_END:    tde_ff <= csr_data;
            CSR_TILT_UP_END:      tue_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // Positions only ever move toward saturated targets, so they stay on the scale.
   a_pos_on_scale: assert property (@(posedge clock) disable iff (reset)
      (rpos_ff <= SCALE) && (tpos_ff <= SCALE))
      else $error("servo position left the scale");

   // The shared divider is never restarted while it still works on a quotient.
   a_div_no_overlap: assert property (@(posedge clock) disable iff (reset)
      div_req.start |-> !div_sts.busy)
      else $error("divider started while busy");

   // An accepted word keeps the request side closed on the following cycle.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> !req_tready)
      else $error("request accepted while a word is in progress");

   // The rotate axis, when it is not commanded, reports a zero angle.
   a_idle_axis_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_data_ff[8]) |-> (rsp_data_ff[7:0] == '0))
      else $error("uncommanded rotate angle is not zero");

endmodule

FILE: tb/sv/testbench.sv
// Self-checking testbench for the two-axis servo ramp generator.
module testbench
   import svr_pkg::*;
();

   // The block is built with its default scale, and the prediction below follows it.
   localparam int SCALE          = DEFAULT_POSITION_SCALE;
   localparam int SETTLE_CYCLES  = 100;
   localparam int STALL_CYCLES   = 300;
   localparam int WATCHDOG_LIMIT = 5000;

   // Codes carried in tuser.
   localparam logic MODE_RAMP = 1'b0;
   localparam logic MODE_JUMP = 1'b1;

   typedef struct packed {
      logic              immediate;
      logic              tick;
      logic [POS_W-1:0]  rotate_target;
      logic [POS_W-1:0]  tilt_target;
      logic [TIME_W-1:0] move_time;
   } head_move_type;

   typedef struct packed {
      logic [ANGLE_W-1:0] rotate_angle;
      logic               rotate_write;
      logic [ANGLE_W-1:0] tilt_angle;
      logic               tilt_write;
      logic               in_position;
   } servo_word_type;

   logic                 clock;
   logic                 reset;
   logic                 req_tvalid;
   logic                 req_tready;
   logic [31:0]          req_tdata;
   logic                 req_tuser;
   logic                 rsp_tvalid;
   logic                 rsp_tready;
   logic [23:0]          rsp_tdata;
   logic                 csr_valid;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [ANGLE_W-1:0]   csr_data;

   two_axis_servo_ramp uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   // Our own copy of the head: end angles, positions, remembered goals, step timing.
   logic [ANGLE_W-1:0]   rot_left_deg  = RESET_ROTATE_LEFT_END;
   logic [ANGLE_W-1:0]   rot_right_deg = RESET_ROTATE_RIGHT_END;
   logic [ANGLE_W-1:0]   tilt_down_deg = RESET_TILT_DOWN_END;
   logic [ANGLE_W-1:0]   tilt_up_deg   = RESET_TILT_UP_END;
   logic [POS_W-1:0]     rot_pos       = '0;
   logic [POS_W-1:0]     tilt_pos      = '0;
   logic [POS_W-1:0]     rot_goal_mem  = NO_TARGET;
   logic [POS_W-1:0]     tilt_goal_mem = NO_TARGET;
   logic                 rot_up        = 1'b0;
   logic                 tilt_up       = 1'b0;
   logic [TIME_W-1:0]    rot_period    = '0;
   logic [TIME_W-1:0]    tilt_period   = '0;
   logic [ELAPSED_W-1:0] rot_wait      = '0;
   logic [ELAPSED_W-1:0] tilt_wait     = '0;
   logic                 head_settled  = 1'b0;

   // Servo commands the block owes us, oldest first.
   servo_word_type commanded_words[$];

   int words_in       = 0;
   int words_out      = 0;
   int bad_words      = 0;
   int angle_settings = 0;
   int req_idle_pct   = 0;
   int rsp_idle_pct   = 0;
   int rsp_hold_left  = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Linear map from a 0..SCALE position onto two end angles, truncated, then clamped.
   function automatic logic [ANGLE_W-1:0] servo_angle(input logic [POS_W-1:0] pos,
                                                      input logic [ANGLE_W-1:0] end0,
                                                      input logic [ANGLE_W-1:0] end1);
      int e0;
      int e1;
      int a;
      int lo;
      int hi;
      e0 = int'(end0);
      e1 = int'(end1);
      a  = e0 + (int'(pos) * (e1 - e0)) / SCALE;
      lo = (e0 < e1) ? e0 : e1;
      hi = (e0 < e1) ? e1 : e0;
      if (a < lo) a = lo;
      if (a > hi) a = hi;
      return ANGLE_W'(a);
   endfunction

   function automatic void plan_axis(input logic [POS_W-1:0] pos,
                                     input logic [POS_W-1:0] goal,
                                     input logic [TIME_W-1:0] ms,
                                     output logic up,
                                     output logic [TIME_W-1:0] period,
                                     output logic [ELAPSED_W-1:0] waited);
      logic [POS_W-1:0] gap;
      gap    = (pos > goal) ? pos - goal : goal - pos;
      up     = pos < goal;
      period = (gap == 0) ? '0 : TIME_W'(ms / gap);
      waited = '0;
   endfunction

   function automatic logic advance_axis(inout logic [POS_W-1:0] pos,
                                         input logic [POS_W-1:0] goal,
                                         input logic up,
                                         input logic [TIME_W-1:0] period,
                                         inout logic [ELAPSED_W-1:0] waited);
      if (pos == goal || waited < period) return 1'b0;
      pos    = up ? pos + 1'b1 : pos - 1'b1;
      waited = '0;
      return 1'b1;
   endfunction

   // Applies one accepted request word to the head and returns the servo word it causes.
   function automatic servo_word_type advance_head(input head_move_type mv);
      servo_word_type   w;
      logic [POS_W-1:0] rt;
      logic [POS_W-1:0] tt;
      w  = '0;
      rt = (mv.rotate_target > SCALE) ? POS_W'(SCALE) : mv.rotate_target;
      tt = (mv.tilt_target > SCALE) ? POS_W'(SCALE) : mv.tilt_target;
      if (mv.tick) begin
         if (rot_wait != '1) rot_wait = rot_wait + 1'b1;
         if (tilt_wait != '1) tilt_wait = tilt_wait + 1'b1;
      end
      if (mv.immediate == MODE_JUMP) begin
         // A jump writes both servos and forgets the goals, so the next ramp re-plans.
         rot_pos        = rt;
         tilt_pos       = tt;
         w.rotate_write = 1'b1;
         w.tilt_write   = 1'b1;
         head_settled   = 1'b1;
         rot_goal_mem   = NO_TARGET;
         tilt_goal_mem  = NO_TARGET;
      end else begin
         if (rot_goal_mem != rt || tilt_goal_mem != tt) begin
            rot_goal_mem  = rt;
            tilt_goal_mem = tt;
            head_settled  = 1'b0;
            plan_axis(rot_pos, rt, mv.move_time, rot_up, rot_period, rot_wait);
            plan_axis(tilt_pos, tt, mv.move_time, tilt_up, tilt_period, tilt_wait);
         end
         // The settled check looks at positions before this word's steps.
         if (rot_pos == rt && tilt_pos == tt) head_settled = 1'b1;
         w.rotate_write = advance_axis(rot_pos, rt, rot_up, rot_period, rot_wait);
         w.tilt_write   = advance_axis(tilt_pos, tt, tilt_up, tilt_period, tilt_wait);
      end
      if (w.rotate_write) w.rotate_angle = servo_angle(rot_pos, rot_left_deg, rot_right_deg);
      if (w.tilt_write) w.tilt_angle = servo_angle(tilt_pos, tilt_down_deg, tilt_up_deg);
      w.in_position = head_settled;
      return w;
   endfunction

   // A goal a few steps from the current position, now and then beyond the scale.
   function automatic logic [POS_W-1:0] near_target(input logic [POS_W-1:0] pos);
      int t;
      if ($urandom_range(19) == 0) return POS_W'($urandom_range(127, SCALE + 1));
      t = int'(pos) + int'($urandom_range(16)) - 8;
      if (t < 0) t = 0;
      if (t > SCALE) t = SCALE;
      return POS_W'(t);
   endfunction

   // Offers one request word, waits for the handshake and records the servo word owed.
   task automatic send_word(input logic mode, input logic tick,
                            input logic [POS_W-1:0] rt, input logic [POS_W-1:0] tt,
                            input logic [TIME_W-1:0] ms);
      head_move_type mv;
      mv.immediate     = mode;
      mv.tick          = tick;
      mv.rotate_target = rt;
      mv.tilt_target   = tt;
      mv.move_time     = ms;
      while ($urandom_range(99) < req_idle_pct) begin
         @(negedge clock);
         req_tvalid = 1'b0;
      end
      @(negedge clock);
      req_tvalid = 1'b1;
      req_tuser  = mode;
      req_tdata  = {2'b00, ms, tt, rt, tick};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      commanded_words.push_back(advance_head(mv));
      words_in++;
   endtask

   task automatic hold_sender_until_drained();
      @(negedge clock);
      req_tvalid = 1'b0;
      while (commanded_words.size() != 0) @(posedge clock);
   endtask

   // Drained and then left alone long enough that no request is still in flight.
   task automatic wait_idle();
      hold_sender_until_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_end_angle(input logic [CSR_IDX_W-1:0] idx,
                                  input logic [ANGLE_W-1:0] deg);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data  = deg;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         CSR_ROTATE_LEFT_END:  rot_left_deg  = deg;
         CSR_ROTATE_RIGHT_END: rot_right_deg = deg;
         CSR_TILT_DOWN_END:    tilt_down_deg = deg;
         CSR_TILT_UP_END:      tilt_up_deg   = deg;
         default: ;
      endcase
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic set_end_angles(input logic [ANGLE_W-1:0] rl, input logic [ANGLE_W-1:0] rr,
                                 input logic [ANGLE_W-1:0] td, input logic [ANGLE_W-1:0] tu);
      write_end_angle(CSR_ROTATE_LEFT_END, rl);
      write_end_angle(CSR_ROTATE_RIGHT_END, rr);
      write_end_angle(CSR_TILT_DOWN_END, td);
      write_end_angle(CSR_TILT_UP_END, tu);
      angle_settings++;
   endtask

   // Hand-picked words on the reset end angles: jumps, saturated goals, zero and
   // maximum durations, a duration change with the same goals, the settled flag
   // lagging the last step by one word, and a reversal.
   task automatic test_directed();
      req_idle_pct = 0;
      rsp_idle_pct = 0;
      angle_settings++;
      send_word(MODE_RAMP, 1'b0, 7'd0, 7'd0, 15'd0);
      send_word(MODE_JUMP, 1'b0, 7'd100, 7'd100, 15'd0);
      send_word(MODE_JUMP, 1'b1, 7'd127, 7'd127, 15'd32767);
      send_word(MODE_JUMP, 1'b0, 7'd50, 7'd33, 15'd0);
      send_word(MODE_RAMP, 1'b0, 7'd52, 7'd31, 15'd0);
      send_word(MODE_RAMP, 1'b1, 7'd52, 7'd31, 15'd32767);
      send_word(MODE_RAMP, 1'b0, 7'd52, 7'd31, 15'd0);
      send_word(MODE_RAMP, 1'b1, 7'd127, 7'd0, 15'd32767);
      send_word(MODE_RAMP, 1'b1, 7'd127, 7'd0, 15'd32767);
      // A goal past the scale clips onto the remembered one, so nothing is re-planned.
      send_word(MODE_RAMP, 1'b1, 7'd101, 7'd0, 15'd32767);
      send_word(MODE_JUMP, 1'b0, 7'd0, 7'd100, 15'd0);
      send_word(MODE_RAMP, 1'b1, 7'd3, 7'd97, 15'd6);
      send_word(MODE_RAMP, 1'b1, 7'd3, 7'd97, 15'd6);
      send_word(MODE_RAMP, 1'b1, 7'd3, 7'd97, 15'd6);
      send_word(MODE_RAMP, 1'b0, 7'd3, 7'd97, 15'd6);
      send_word(MODE_RAMP, 1'b0, 7'd0, 7'd100, 15'd1);
      send_word(MODE_RAMP, 1'b1, 7'd0, 7'd100, 15'd1);
      send_word(MODE_RAMP, 1'b0, 7'd0, 7'd100, 15'd1);
      send_word(MODE_JUMP, 1'b1, 7'd0, 7'd0, 15'h5555);
      // Same goals as the jump, but the jump forgot them and forces a new plan.
      send_word(MODE_RAMP, 1'b1, 7'd0, 7'd0, 15'h2AAA);
   endtask

   // Mostly complete short ramps, some after a jump, with random timing; the rest
   // are random words and ramps cut off before they settle.
   task automatic test_random_ramps(input int count, input int req_pct, input int rsp_pct,
                                    input logic [ANGLE_W-1:0] rl,
                                    input logic [ANGLE_W-1:0] rr,
                                    input logic [ANGLE_W-1:0] td,
                                    input logic [ANGLE_W-1:0] tu);
      int               sent;
      int               run_len;
      int               run_cap;
      int               dr;
      int               dt;
      logic [POS_W-1:0] rt;
      logic [POS_W-1:0] tt;
      logic [TIME_W-1:0] ms;
      wait_idle();
      set_end_angles(rl, rr, td, tu);
      req_idle_pct = req_pct;
      rsp_idle_pct = rsp_pct;
      sent = 0;
      while (sent < count) begin
         if ($urandom_range(99) < 15) begin
            send_word($urandom_range(1) ? MODE_JUMP : MODE_RAMP, 1'($urandom_range(1)),
                      POS_W'($urandom_range(127)), POS_W'($urandom_range(127)),
                      TIME_W'($urandom_range(32767)));
            sent++;
         end else begin
            if ($urandom_range(9) < 2) begin
               send_word(MODE_JUMP, 1'($urandom_range(1)), POS_W'($urandom_range(SCALE)),
                         POS_W'($urandom_range(SCALE)), TIME_W'($urandom_range(32767)));
               sent++;
            end
            rt = near_target(rot_pos);
            tt = near_target(tilt_pos);
            dr = int'(rt) - int'(rot_pos);
            dt = int'(tt) - int'(tilt_pos);
            if (dr < 0) dr = -dr;
            if (dt < 0) dt = -dt;
            if (dt > dr) dr = dt;
            ms = TIME_W'(dr * int'($urandom_range(2)) + int'($urandom_range(3)));
            run_cap = $urandom_range(60, 5);
            run_len = 0;
            do begin
               send_word(MODE_RAMP, $urandom_range(3) != 0, rt, tt,
                         (run_len == 0) ? ms : TIME_W'($urandom_range(32767)));
               sent++;
               run_len++;
            end while (!head_settled && run_len < run_cap);
         end
      end
   endtask

   // The receiver goes deaf for a long stretch while words keep coming, so the
   // block backs up; then the sender waits for every owed word before going on.
   task automatic test_backpressure();
      int i;
      wait_idle();
      set_end_angles(ANGLE_W'($urandom_range(255)), ANGLE_W'($urandom_range(255)),
                     ANGLE_W'($urandom_range(255)), ANGLE_W'($urandom_range(255)));
      req_idle_pct = 0;
      rsp_idle_pct = 0;
      @(posedge clock);
      rsp_hold_left = STALL_CYCLES;
      for (i = 0; i < 12; i++) begin
         send_word(MODE_RAMP, 1'b1, near_target(rot_pos), near_target(tilt_pos),
                   TIME_W'($urandom_range(2)));
      end
      hold_sender_until_drained();
      for (i = 0; i < 24; i++) begin
         send_word((i % 8 == 0) ? MODE_JUMP : MODE_RAMP, 1'($urandom_range(1)),
                   POS_W'($urandom_range(127)), POS_W'($urandom_range(127)),
                   TIME_W'($urandom_range(8)));
      end
   endtask

   // Receiver ready: a counted hold-off when one is asked for, random otherwise.
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_hold_left > 0) begin
            rsp_tready    = 1'b0;
            rsp_hold_left = rsp_hold_left - 1;
         end else begin
            rsp_tready = ($urandom_range(99) >= rsp_idle_pct);
         end
      end
   end

   // Every servo word taken from the block must match the oldest one owed.
   always @(posedge clock) begin
      servo_word_type want;
      servo_word_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.rotate_angle = rsp_tdata[7:0];
         got.rotate_write = rsp_tdata[8];
         got.tilt_angle   = rsp_tdata[16:9];
         got.tilt_write   = rsp_tdata[17];
         got.in_position  = rsp_tdata[18];
         if (commanded_words.size() == 0) begin
            bad_words++;
            $display("%0t: unexpected servo word: rot %0d/%0b tilt %0d/%0b in_pos %0b",
                     $time, got.rotate_angle, got.rotate_write, got.tilt_angle,
                     got.tilt_write, got.in_position);
         end else begin
            want = commanded_words.pop_front();
            words_out++;
            if (got !== want) begin
               bad_words++;
               $display({"%0t: servo word differs: expected rot %0d/%0b tilt %0d/%0b",
                         " in_pos %0b, actual rot %0d/%0b tilt %0d/%0b in_pos %0b"},
                        $time, want.rotate_angle, want.rotate_write, want.tilt_angle,
                        want.tilt_write, want.in_position, got.rotate_angle,
                        got.rotate_write, got.tilt_angle, got.tilt_write,
                        got.in_position);
            end
         end
      end
   end

   // Ends the run once nothing has moved on any channel for too long.
   initial begin
      int quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
             (csr_valid && csr_ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("%0t: no handshake for %0d cycles, %0d servo words still owed",
               $time, WATCHDOG_LIMIT, commanded_words.size());
      $display("two_axis_servo_ramp: mismatch");
      $finish;
   end

   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = MODE_RAMP;
      csr_valid  = 1'b0;
      csr_index  = CSR_ROTATE_LEFT_END;
      csr_data   = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed();
      // Full-range ends reversed on both axes; busy receiver.
      test_random_ramps(250, 24, 75, 8'd255, 8'd0, 8'd0, 8'd255);
      // Rotate ends equal so its angle never moves; busy sender.
      test_random_ramps(250, 75, 24, 8'd90, 8'd90, 8'd0, 8'd180);
      // Random ends within the servo range, no idling at all.
      test_random_ramps(250, 0, 0, ANGLE_W'($urandom_range(180)),
                        ANGLE_W'($urandom_range(180)), ANGLE_W'($urandom_range(180)),
                        ANGLE_W'($urandom_range(180)));
      test_backpressure();
      wait_idle();

      $display("Ran %0d request words and checked %0d servo words over %0d end-angle settings,",
               words_in, words_out, angle_settings);
      $display("with jumps, clipped goals, ramps to completion and a long output stall.");
      if (bad_words == 0) begin
         $display("two_axis_servo_ramp: match");
      end else begin
         $display("two_axis_servo_ramp: mismatch");
      end
      $finish;
   end

endmodule

FILE: files.f
sv/svr_pkg.sv
sv/svr_div.sv
sv/two_axis_servo_ramp.sv
tb/sv/testbench.sv
